// ===== rtl/core/delayed_frame_episode_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// delayed frame episode monitor assertion macros
// shared property wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef DELAYED_FRAME_EPISODE_MONITOR_ASSERT_SVH
`define DELAYED_FRAME_EPISODE_MONITOR_ASSERT_SVH

// same-cycle implication
`define DFEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dfem_pkg.sv =====
// ----------------------------------------------------------------------------
// dfem_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package dfem_pkg;

    // input word and configuration
    localparam int IN_W         = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int THR_W        = 32;
    localparam int LIM_W        = 8;
    localparam int RUN_W        = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LIMIT   = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET = 32'd30000000;
    localparam logic [LIM_W-1:0] LIM_RESET = 8'd60;
    localparam logic [RUN_W-1:0] RUN_RESET = 4'd3;

    // result word
    localparam int CNT_W        = 9;
    localparam int MS_W         = 13;
    localparam int OUT_FIELDS_W = CNT_W + 2 * MS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // ns to ms scaling and divider sizing
    localparam int NS_W = 20;
    localparam logic [NS_W-1:0] NS_PER_MS = 20'd1000000;
    localparam int PROD_W = CNT_W + NS_W;
    localparam int DIV_W  = PROD_W + MS_W;
    localparam int STEP_W = $clog2(MS_W);

    // default saturation width of a wait
    localparam int DURATION_BITS_DEF = 32;

    typedef struct packed {
        logic accept;
        logic step;
        logic last_max;
        logic last_avg;
        logic out_load;
    } dfem_cmd_t;

    typedef struct packed {
        logic report;
    } dfem_stat_t;

endpackage

// ===== rtl/core/dfem_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfem_ctrl
// sequencer for word intake, the two divisions and the result register
// ----------------------------------------------------------------------------
`include "delayed_frame_episode_monitor_assert.svh"

module dfem_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  dfem_pkg::dfem_stat_t stat,
    output dfem_pkg::dfem_cmd_t  cmd
);
    import dfem_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DIV_MAX = 2'd1;
    localparam logic [1:0] ST_DIV_AVG = 2'd2;
    localparam logic [1:0] ST_HOLD    = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              step_last;

    assign step_last = (step_reg == STEP_W'(MS_W - 1));
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = s_tvalid;
                step_next  = '0;
                if (s_tvalid && stat.report)
                begin
                    state_next = ST_DIV_MAX;
                end
            end
            ST_DIV_MAX:
            begin
                cmd.step     = 1'b1;
                cmd.last_max = step_last;
                step_next    = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                begin
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG:
            begin
                cmd.step     = 1'b1;
                cmd.last_avg = step_last;
                step_next    = step_last ? '0 : step_reg + 1'b1;
                if (step_last)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `DFEM_ASSERT_NXT(a_report_starts_div, clk, rst_n, cmd.accept && stat.report, state_reg == ST_DIV_MAX, "report did not start division")
    `DFEM_ASSERT_IMP(a_valid_from_load, clk, rst_n, $rose(m_valid_reg), $past(cmd.out_load), "result valid without a load")
    `DFEM_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !m_valid_reg || m_tready, "pending result overwritten")
    `DFEM_ASSERT_IMP(a_step_bound, clk, rst_n, state_reg == ST_DIV_MAX || state_reg == ST_DIV_AVG, step_reg < STEP_W'(MS_W), "division step count out of range")
    `DFEM_ASSERT_NXT(a_avg_done_to_hold, clk, rst_n, cmd.last_avg, state_reg == ST_HOLD, "mean division did not end in hold")

endmodule

// ===== rtl/core/dfem_dpath.sv =====
// ----------------------------------------------------------------------------
// dfem_dpath
// episode state, config registers, shared restoring divider, result register
// ----------------------------------------------------------------------------
module dfem_dpath #(
    parameter int DURATION_BITS = dfem_pkg::DURATION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dfem_pkg::IN_W-1:0]         wait_duration_ns,
    input  logic                              cfg_we,
    input  logic [dfem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfem_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  dfem_pkg::dfem_cmd_t               cmd,
    output dfem_pkg::dfem_stat_t              stat,
    output logic [dfem_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import dfem_pkg::*;

    localparam int SAT_W  = (DURATION_BITS < IN_W) ? DURATION_BITS : IN_W;
    localparam int TOT_W  = SAT_W + 10;
    localparam int NTOT_W = SAT_W + RUN_W;

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [RUN_W-1:0] nlim_reg;

    // episode state
    logic [TOT_W-1:0]  tot_reg,  tot_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [NTOT_W-1:0] ntot_reg, ntot_next;
    logic [RUN_W-1:0]  run_reg,  run_next;
    logic [SAT_W-1:0]  long_reg, long_next;

    // divider and snapshot
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [MS_W-1:0]   quo_reg;
    logic [MS_W-1:0]   quo_next;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [PROD_W-1:0] prod_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [TOT_W-1:0]  sum_reg;
    logic [MS_W-1:0]   max_ms_reg;

    // result word
    logic [CNT_W-1:0] out_cnt_reg;
    logic [MS_W-1:0]  out_avg_reg;
    logic [MS_W-1:0]  out_max_reg;

    logic [SAT_W-1:0] dur_sat;
    logic             slow;
    logic             open_ep;
    logic             report;
    logic [CNT_W-1:0] n_cur;
    logic [TOT_W-1:0] sum_cur;

    // saturate the wait to the stored duration width
    generate
        if (SAT_W < IN_W)
        begin : g_sat
            assign dur_sat = (|wait_duration_ns[IN_W-1:SAT_W]) ? {SAT_W{1'b1}}
                                                                : wait_duration_ns[SAT_W-1:0];
        end
        else
        begin : g_nosat
            assign dur_sat = wait_duration_ns[SAT_W-1:0];
        end
    endgenerate

    assign slow    = (THR_W'(dur_sat) >= thr_reg);
    assign open_ep = (tot_reg != '0);
    assign n_cur   = cnt_reg - CNT_W'(run_reg);
    assign sum_cur = tot_reg - TOT_W'(ntot_reg);

    always_comb
    begin
        tot_next  = tot_reg;
        cnt_next  = cnt_reg;
        ntot_next = ntot_reg;
        run_next  = run_reg;
        long_next = long_reg;
        report    = 1'b0;
        if (slow)
        begin
            if (cnt_reg < CNT_W'(lim_reg))
            begin
                ntot_next = '0;
                run_next  = '0;
                tot_next  = tot_reg + TOT_W'(dur_sat);
                cnt_next  = cnt_reg + 1'b1;
                long_next = (dur_sat > long_reg) ? dur_sat : long_reg;
            end
            else
            begin
                // report the old episode, this wait opens a new one
                report    = 1'b1;
                ntot_next = '0;
                run_next  = '0;
                tot_next  = TOT_W'(dur_sat);
                cnt_next  = CNT_W'(1);
                long_next = dur_sat;
            end
        end
        else if (open_ep)
        begin
            if (run_reg < nlim_reg)
            begin
                tot_next  = tot_reg + TOT_W'(dur_sat);
                cnt_next  = cnt_reg + 1'b1;
                ntot_next = ntot_reg + NTOT_W'(dur_sat);
                run_next  = run_reg + 1'b1;
            end
            else
            begin
                report    = 1'b1;
                tot_next  = '0;
                cnt_next  = '0;
                ntot_next = '0;
                run_next  = '0;
                long_next = '0;
            end
        end
    end

    assign stat.report = report;

    // restoring divider step, one quotient bit per cycle
    assign diff     = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign ge       = !diff[DIV_W];
    assign quo_next = {quo_reg[MS_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            lim_reg  <= LIM_RESET;
            nlim_reg <= RUN_RESET;
            tot_reg  <= '0;
            cnt_reg  <= '0;
            ntot_reg <= '0;
            run_reg  <= '0;
            long_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SLOW_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    CFG_SLOW_LIMIT:     lim_reg  <= cfg_data[LIM_W-1:0];
                    CFG_NORMAL_LIMIT:   nlim_reg <= cfg_data[RUN_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.accept)
            begin
                tot_reg  <= tot_next;
                cnt_reg  <= cnt_next;
                ntot_reg <= ntot_next;
                run_reg  <= run_next;
                long_reg <= long_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && report)
        begin
            // snapshot the closing episode, start with the maximum
            n_reg    <= n_cur;
            sum_reg  <= sum_cur;
            prod_reg <= PROD_W'(n_cur) * PROD_W'(NS_PER_MS);
            rem_reg  <= DIV_W'(long_reg);
            dvs_reg  <= DIV_W'(NS_PER_MS) << (MS_W - 1);
            quo_reg  <= '0;
        end
        else if (cmd.last_max)
        begin
            max_ms_reg <= quo_next;
            rem_reg    <= DIV_W'(sum_reg);
            dvs_reg    <= DIV_W'(prod_reg) << (MS_W - 1);
            quo_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : rem_reg;
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            out_cnt_reg <= n_reg;
            out_avg_reg <= (n_reg == '0) ? '0 : quo_reg;
            out_max_reg <= max_ms_reg;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_max_reg, out_avg_reg, out_cnt_reg};

endmodule

// ===== rtl/core/delayed_frame_episode_monitor.sv =====
// ----------------------------------------------------------------------------
// delayed_frame_episode_monitor
// groups slow frame waits into episodes and reports count, mean and maximum
// ----------------------------------------------------------------------------
//  channel   signals                               carries
//  s_*       s_tvalid s_tready s_tdata[31:0]       one frame wait in ns per word
//  m_*       m_tvalid m_tready m_tdata[39:0]       one episode report per word
//  cfg_*     cfg_valid cfg_ready cfg_index cfg_data register write, always ready
//
//  a word that gives no report leaves the input ready, the next word follows
//  a word that closes an episode runs the shared divider twice, 13 steps each
//  (maximum, then mean), so the input is busy through both divisions and the
//  hold state, plus any wait for the result register to free up
//  the result register lets a new word in while a report waits on m_tready
//  rst_n clears the episode and loads the register defaults, no clearing pass
// ----------------------------------------------------------------------------
module delayed_frame_episode_monitor #(
    parameter int DURATION_BITS = dfem_pkg::DURATION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dfem_pkg::IN_W-1:0]         s_tdata,   // [31:0] wait_duration_ns
    // report words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dfem_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [8:0] slow_count,
                                                         // [21:9] average_ms,
                                                         // [34:22] maximum_ms, rest zero
    // register writes: 0 slow_threshold_ns, 1 slow_count_limit, 2 normal_run_limit
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfem_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dfem_pkg::*;

    dfem_cmd_t  cmd;
    dfem_stat_t stat;

    // writes must come only while idle, the block does not enforce it, and they are always taken
    assign cfg_ready = 1'b1;

    // sequencer: intake, division steps, result handoff
    dfem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // episode bookkeeping, divider and result register
    dfem_dpath #(
        .DURATION_BITS (DURATION_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .wait_duration_ns (s_tdata),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delayed frame episode monitor testbench
// walks a directed table of waits and register writes, then random phases of
// slow and normal bursts, and checks every report word against a local model or a hand-written report
// ----------------------------------------------------------------------------
module testbench;

    import dfem_pkg::*;

    // index 3 maps to no register, a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int  ONE_MS_NS     = 1_000_000;
    localparam int  MS_CEILING    = 8191;
    localparam int  DRAIN_CYCLES  = 40;     // covers a report's divisions plus margin
    localparam int  HOLD_CYCLES   = 400;
    localparam int  RANDOM_PHASES = 8;
    localparam int  PHASE_WAITS   = 66;
    localparam int  SHOWN_ERRORS  = 10;

    // one report word, fields packed from the lowest bit up as on m_tdata
    typedef struct packed {
        logic [MS_W-1:0]  maximum_ms;
        logic [MS_W-1:0]  average_ms;
        logic [CNT_W-1:0] slow_count;
    } episode_report_t;

    // one row of the directed table
    typedef struct packed {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [31:0]          value;
        bit                   typed;
        episode_report_t      want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // register copies, loaded with the reset values of the block
    logic [THR_W-1:0] threshold_ns = THR_RESET;
    logic [LIM_W-1:0] slow_limit   = LIM_RESET;
    logic [RUN_W-1:0] run_limit    = RUN_RESET;

    // episode being tracked
    logic [41:0] ep_total_ns     = '0;
    logic [8:0]  ep_count        = '0;
    logic [35:0] absorbed_ns     = '0;
    logic [3:0]  absorbed_run    = '0;
    logic [31:0] ep_longest_ns   = '0;

    episode_report_t pending_reports[$];
    plan_row_t       directed_plan[$];
    int              mismatch_count    = 0;
    bit              quiet_mode        = 1'b0;
    bit              hold_off_request  = 1'b0;

    delayed_frame_episode_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ns to ms, truncated, clipped to the field
    function automatic logic [MS_W-1:0] ns_to_ms(input logic [41:0] ns);
        logic [41:0] ms;
        ms = ns / ONE_MS_NS;
        return (ms > MS_CEILING) ? MS_W'(MS_CEILING) : ms[MS_W-1:0];
    endfunction

    // build the report of the open episode and clear it
    function automatic episode_report_t close_episode();
        episode_report_t rep;
        logic [8:0]      slow_n;
        logic [41:0]     slow_sum;
        slow_n   = ep_count - 9'(absorbed_run);
        slow_sum = ep_total_ns - 42'(absorbed_ns);
        rep.slow_count = slow_n;
        // an empty report carries a zero mean, no division
        rep.average_ms = (slow_n != 0) ? ns_to_ms(slow_sum / slow_n) : '0;
        rep.maximum_ms = ns_to_ms(42'(ep_longest_ns));
        ep_total_ns   = '0;
        ep_count      = '0;
        absorbed_ns   = '0;
        absorbed_run  = '0;
        ep_longest_ns = '0;
        return rep;
    endfunction

    // advance the episode by one wait, returns 1 when a report comes out
    function automatic bit track_wait(input logic [31:0] wait_ns, output episode_report_t rep);
        bit closes;
        closes = 1'b0;
        rep    = '0;
        if (wait_ns >= threshold_ns) begin
            if (ep_count < 9'(slow_limit)) begin
                // a slow wait breaks the run of normal waits
                absorbed_ns  = '0;
                absorbed_run = '0;
            end
            else begin
                // episode full, report it and let this wait open the next one
                rep    = close_episode();
                closes = 1'b1;
            end
            ep_total_ns = ep_total_ns + 42'(wait_ns);
            ep_count    = ep_count + 9'd1;
            if (wait_ns > ep_longest_ns)
                ep_longest_ns = wait_ns;
        end
        else if (ep_total_ns != 0) begin
            if (absorbed_run < run_limit) begin
                ep_total_ns  = ep_total_ns + 42'(wait_ns);
                ep_count     = ep_count + 9'd1;
                absorbed_ns  = absorbed_ns + 36'(wait_ns);
                absorbed_run = absorbed_run + 4'd1;
            end
            else begin
                rep    = close_episode();
                closes = 1'b1;
            end
        end
        // a normal wait with no open episode is dropped
        return closes;
    endfunction

    // random wait, mostly on the slow or normal side of the current threshold
    function automatic logic [31:0] draw_wait(input bit slow);
        logic [32:0] above;
        if ($urandom_range(9) == 0)
            return $urandom;
        if (slow) begin
            case ($urandom_range(3))
                0: return threshold_ns;
                1:
                begin
                    above = threshold_ns + $urandom_range(20_000_000);
                    return above[32] ? 32'hFFFF_FFFF : above[31:0];
                end
                2: return $urandom_range(32'hFFFF_FFFF, threshold_ns);
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (threshold_ns == 0)
            return $urandom;
        case ($urandom_range(3))
            0: return threshold_ns - 1;
            1: return $urandom_range(threshold_ns - 1, 0);
            2: return '0;
            default: return (threshold_ns - 1) >> $urandom_range(8);
        endcase
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        directed_plan.push_back('{1'b1, idx, v, 1'b0, episode_report_t'('0)});
    endfunction

    function automatic void add_wait(input logic [31:0] v);
        directed_plan.push_back('{1'b0, CFG_UNUSED, v, 1'b0, episode_report_t'('0)});
    endfunction

    function automatic void add_wait_report(input logic [31:0] v, input int cnt,
                                            input int avg, input int max_ms);
        episode_report_t rep;
        rep.slow_count = CNT_W'(cnt);
        rep.average_ms = MS_W'(avg);
        rep.maximum_ms = MS_W'(max_ms);
        directed_plan.push_back('{1'b0, CFG_UNUSED, v, 1'b1, rep});
    endfunction

    // offer one wait word, optionally after a gap, and record what it reports
    task automatic send_wait(input logic [31:0] wait_ns, input bit typed,
                             input episode_report_t want);
        int              gap;
        bit              closes;
        episode_report_t predicted;
        gap = 0;
        if (!quiet_mode)
            while ($urandom_range(99) < 33)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= wait_ns;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        closes = track_wait(wait_ns, predicted);
        // typed rows carry a hand-written report in place of the computed one
        if (closes || typed)
            pending_reports.push_back(typed ? want : predicted);
    endtask

    // register write, only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        // a wait with no report may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLOW_THRESHOLD: threshold_ns = value;
            CFG_SLOW_LIMIT:     slow_limit   = value[LIM_W-1:0];
            CFG_NORMAL_LIMIT:   run_limit    = value[RUN_W-1:0];
            default: ;
        endcase
    endtask

    // stimulus: reset, directed table, random phases, drain
    initial
    begin : wait_source
        int              left;
        logic [LIM_W-1:0] lim_pick;
        logic [RUN_W-1:0] run_pick;
        logic [31:0]     thr_pick;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SLOW_THRESHOLD;
        cfg_data  <= '0;

        // defaults: threshold 30 ms, slow limit 60, normal run limit 3
        add_wait(32'd0);                        // no open episode, dropped
        add_wait(32'd29_999_999);               // just below threshold, dropped
        add_wait(32'd30_000_000);               // exactly at threshold opens
        add_wait(32'd0);
        add_wait(32'd1000);
        add_wait(32'd5);
        add_wait_report(32'd7, 1, 30, 30);      // fourth normal wait closes
        add_wait(32'hFFFF_FFFF);
        add_wait(32'd0);
        add_wait(32'd31_000_000);               // slow wait restarts the normal run
        add_wait(32'd1);
        add_wait(32'd2);
        add_wait(32'd3);
        add_wait(32'h0055_AA55);
        // limits of one, upper data bits must be ignored
        add_write(CFG_SLOW_LIMIT, 32'hFFFF_FF01);
        add_write(CFG_NORMAL_LIMIT, 32'hFFFF_FFF1);
        add_wait(32'd40_000_000);
        add_wait_report(32'd50_000_000, 1, 40, 40);   // full episode, new one opens
        add_wait(32'd0);
        add_wait_report(32'd0, 1, 50, 50);
        // zero limits: empty report, then immediate close on a normal wait
        add_write(CFG_SLOW_LIMIT, 32'd0);
        add_write(CFG_NORMAL_LIMIT, 32'd0);
        add_wait_report(32'hFFFF_FFFF, 0, 0, 0);
        add_wait_report(32'd100, 1, 4294, 4294);
        // threshold extremes and largest limits
        add_write(CFG_SLOW_THRESHOLD, 32'd0);
        add_write(CFG_SLOW_LIMIT, 32'h0000_00FF);
        add_write(CFG_NORMAL_LIMIT, 32'h0000_000F);
        add_write(CFG_UNUSED, 32'hFFFF_FFFF);
        add_wait(32'd0);                        // slow waits of zero length
        add_wait(32'd0);
        add_write(CFG_SLOW_THRESHOLD, 32'hFFFF_FFFF);
        add_wait(32'hFFFF_FFFE);                // zero total counts as no episode
        add_wait(32'hFFFF_FFFF);
        add_wait(32'd123);
        // limit lowered under the running count, next slow wait reports
        add_write(CFG_SLOW_LIMIT, 32'hABCD_0102);
        add_wait(32'hFFFF_FFFF);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_write)
                write_register(directed_plan[i].reg_index, directed_plan[i].value);
            else
                send_wait(directed_plan[i].value, directed_plan[i].typed,
                          directed_plan[i].want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       thr_pick = 32'd0;
                1:       thr_pick = 32'hFFFF_FFFF;
                2:       thr_pick = $urandom;
                default: thr_pick = $urandom_range(80_000_000, 1_000_000);
            endcase
            case (phase)
                0:       lim_pick = 8'd1;
                1:       lim_pick = 8'd255;
                3:       lim_pick = LIM_W'($urandom_range(255, 1));
                default: lim_pick = LIM_W'($urandom_range(6, 1));
            endcase
            case (phase)
                0:       run_pick = 4'd15;
                1:       run_pick = 4'd1;
                default: run_pick = RUN_W'($urandom_range(15, 1));
            endcase
            write_register(CFG_SLOW_THRESHOLD, thr_pick);
            write_register(CFG_SLOW_LIMIT, ($urandom & 32'hFFFF_FF00) | 32'(lim_pick));
            write_register(CFG_NORMAL_LIMIT, ($urandom & 32'hFFFF_FFF0) | 32'(run_pick));

            // phase 0 reports on every wait, so a long hold fills the block
            if (phase == 0)
                hold_off_request = 1'b1;
            // one phase runs both sides at full rate
            quiet_mode = (phase == 2);

            // bursts of slow waits followed by runs of normal waits
            left = PHASE_WAITS;
            while (left > 0) begin
                repeat ($urandom_range(4, 1)) begin
                    send_wait(draw_wait(1'b1), 1'b0, '0);
                    left--;
                end
                repeat ($urandom_range(int'(run_limit) + 2, 0)) begin
                    send_wait(draw_wait(1'b0), 1'b0, '0);
                    left--;
                end
            end
        end
        quiet_mode = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // report sink: random stalls, one long hold, check against oldest report
    initial
    begin : report_sink
        int              hold_left;
        episode_report_t seen;
        episode_report_t want;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                seen = episode_report_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("%0t unexpected report word: count %0d avg %0d max %0d",
                                 $time, seen.slow_count, seen.average_ms, seen.maximum_ms);
                end
                else begin
                    want = pending_reports.pop_front();
                    if (seen.slow_count != want.slow_count
                        || seen.average_ms != want.average_ms
                        || seen.maximum_ms != want.maximum_ms) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS)
                            $display("%0t report mismatch: exp count %0d avg %0d max %0d, %s %0d %0d %0d",
                                     $time, want.slow_count, want.average_ms,
                                     want.maximum_ms, "got", seen.slow_count,
                                     seen.average_ms, seen.maximum_ms);
                    end
                end
            end
            if (hold_off_request) begin
                hold_left        = HOLD_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet_mode || ($urandom_range(99) >= 33);
        end
    end

    // run limit, many times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
